FILE: rtl/lbc_pkg.sv
package lbc_pkg;

  localparam int ENTRIES_DEFAULT = 32;

  localparam int MODE_W    = 2;
  localparam int DEVICE_W  = 8;
  localparam int BLOCK_W   = 32;
  localparam int INDEX_W   = 5;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 8;
  localparam int STATUS_W  = 2;

  localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PIN     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNPIN   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFREE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [DEVICE_W-1:0] tag_device;
    logic [BLOCK_W-1:0]  tag_block;
    logic                contents_valid;
    logic [COUNT_W-1:0]  reference_count;
    logic [TIME_W-1:0]   last_use_time;
  } entry_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  result_entry;
    logic                was_hit;
    logic                disk_read_needed;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

FILE: rtl/lbc_if.sv
interface lbc_req_if;
  logic                          valid;
  logic                          ready;
  logic [lbc_pkg::MODE_W-1:0]    mode;
  logic [lbc_pkg::DEVICE_W-1:0]  device;
  logic [lbc_pkg::BLOCK_W-1:0]   block_number;
  logic [lbc_pkg::INDEX_W-1:0]   entry_index;
  logic [lbc_pkg::TIME_W-1:0]    current_time;

  modport source (output valid, mode, device, block_number, entry_index, current_time,
                  input ready);
  modport sink (input valid, mode, device, block_number, entry_index, current_time,
                output ready);
endinterface

interface lbc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lbc_pkg::INDEX_W-1:0]   result_entry;
  logic                          was_hit;
  logic                          disk_read_needed;
  logic [lbc_pkg::STATUS_W-1:0]  status;

  modport source (output valid, result_entry, was_hit, disk_read_needed, status,
                  input ready);
  modport sink (input valid, result_entry, was_hit, disk_read_needed, status,
                output ready);
endinterface

FILE: rtl/lbc_ram.sv
module lbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lbc_ctrl.sv
module lbc_ctrl #(
  parameter int ENTRIES = lbc_pkg::ENTRIES_DEFAULT,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  logic              rst,
  lbc_req_if.sink           req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output lbc_pkg::rsp_t     rsp_data,
  output logic              mem_we,
  output logic [IDX_W-1:0]  mem_waddr,
  output lbc_pkg::entry_t   mem_wdata,
  output logic [IDX_W-1:0]  mem_raddr,
  input  lbc_pkg::entry_t   mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_MODIFY,
    S_DECIDE,
    S_OUT
  } state_t;

  state_t state;

  logic [lbc_pkg::MODE_W-1:0]   mode_q;
  logic [lbc_pkg::DEVICE_W-1:0] dev_q;
  logic [lbc_pkg::BLOCK_W-1:0]  blk_q;
  logic [lbc_pkg::INDEX_W-1:0]  idx_q;
  logic [lbc_pkg::TIME_W-1:0]   now_q;

  logic [IDX_W:0]   cnt;
  logic [IDX_W-1:0] raddr_q;
  logic [ENTRIES-1:0] written;

  logic                        hit_found;
  logic [IDX_W-1:0]            hit_addr;
  lbc_pkg::entry_t             hit_ent;
  logic                        vic_found;
  logic [IDX_W-1:0]            vic_addr;
  logic [lbc_pkg::TIME_W-1:0]  vic_time;

  lbc_pkg::entry_t  cur;
  lbc_pkg::rsp_t    res;
  logic [IDX_W-1:0] idx_addr;
  logic             accept;
  logic             idx_oob;
  logic             scan_last;
  logic             tag_match;
  logic             better_victim;

  assign req.ready = (state == S_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign rsp_valid = (state == S_OUT);
  assign idx_addr  = IDX_W'(idx_q);
  assign idx_oob   = (32'(req.entry_index) >= 32'(ENTRIES));
  assign scan_last = (cnt == (IDX_W+1)'(ENTRIES));
  assign mem_raddr = (state == S_SCAN) ? cnt[IDX_W-1:0] : idx_addr;

  // Entries never written since reset read as all zero
  assign cur = written[raddr_q] ? mem_rdata : '0;

  assign tag_match = (cur.tag_device == dev_q) && (cur.tag_block == blk_q);
  assign better_victim = (cur.reference_count == '0) &&
                         (!vic_found || (cur.last_use_time < vic_time));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_addr;
    mem_wdata = cur;
    res       = '0;
    case (state)
      S_DECIDE: begin
        if (hit_found) begin
          res.result_entry = lbc_pkg::INDEX_W'(hit_addr);
          res.was_hit      = 1'b1;
          mem_waddr        = hit_addr;
          mem_wdata        = hit_ent;
          if (hit_ent.reference_count == lbc_pkg::COUNT_MAX) begin
            res.status = lbc_pkg::STATUS_REFUSED;
          end else begin
            mem_we                    = 1'b1;
            mem_wdata.reference_count = hit_ent.reference_count + 1'b1;
            mem_wdata.contents_valid  = 1'b1;
            res.disk_read_needed      = !hit_ent.contents_valid;
            res.status                = lbc_pkg::STATUS_OK;
          end
        end else if (vic_found) begin
          mem_we                    = 1'b1;
          mem_waddr                 = vic_addr;
          mem_wdata.tag_device      = dev_q;
          mem_wdata.tag_block       = blk_q;
          mem_wdata.contents_valid  = 1'b1;
          mem_wdata.reference_count = lbc_pkg::COUNT_W'(1);
          mem_wdata.last_use_time   = vic_time;
          res.result_entry          = lbc_pkg::INDEX_W'(vic_addr);
          res.disk_read_needed      = 1'b1;
          res.status                = lbc_pkg::STATUS_OK;
        end else begin
          res.status = lbc_pkg::STATUS_NOFREE;
        end
      end
      S_MODIFY: begin
        res.result_entry = idx_q;
        res.status       = lbc_pkg::STATUS_OK;
        if (mode_q == lbc_pkg::MODE_PIN) begin
          if (cur.reference_count == lbc_pkg::COUNT_MAX) begin
            res.status = lbc_pkg::STATUS_REFUSED;
          end else begin
            mem_we                    = 1'b1;
            mem_wdata.reference_count = cur.reference_count + 1'b1;
          end
        end else if (cur.reference_count == '0) begin
          res.status = lbc_pkg::STATUS_REFUSED;
        end else begin
          mem_we                    = 1'b1;
          mem_wdata.reference_count = cur.reference_count - 1'b1;
          // stamp only when a release drops the last reference
          if (mode_q == lbc_pkg::MODE_RELEASE &&
              cur.reference_count == lbc_pkg::COUNT_W'(1)) begin
            mem_wdata.last_use_time = now_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    raddr_q <= mem_raddr;
    if (rst) begin
      state   <= S_IDLE;
      written <= '0;
    end else begin
      if (mem_we) begin
        written[mem_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            mode_q    <= req.mode;
            dev_q     <= req.device;
            blk_q     <= req.block_number;
            idx_q     <= req.entry_index;
            now_q     <= req.current_time;
            cnt       <= '0;
            hit_found <= 1'b0;
            vic_found <= 1'b0;
            if (req.mode == lbc_pkg::MODE_ACQUIRE) begin
              state <= S_SCAN;
            end else if (idx_oob) begin
              rsp_data <= '{result_entry: req.entry_index, was_hit: 1'b0,
                            disk_read_needed: 1'b0, status: lbc_pkg::STATUS_REFUSED};
              state    <= S_OUT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_SCAN: begin
          // cnt issues the next read; raddr_q names the entry now on the data bus
          if (cnt != '0) begin
            if (!hit_found && tag_match) begin
              hit_found <= 1'b1;
              hit_addr  <= raddr_q;
              hit_ent   <= cur;
            end
            if (better_victim) begin
              vic_found <= 1'b1;
              vic_addr  <= raddr_q;
              vic_time  <= cur.last_use_time;
            end
          end
          if (scan_last) begin
            state <= S_DECIDE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_READ: begin
          state <= S_MODIFY;
        end
        S_MODIFY, S_DECIDE: begin
          rsp_data <= res;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/lru_block_buffer_cache_core.sv
// Buffer cache tag table with LRU replacement of unreferenced entries.
// Requests come in on req (valid/ready): mode selects acquire, release, pin
// or unpin. Each request yields exactly one result on rsp (valid/ready):
// the granted or addressed entry, hit and disk-read marks, and a status.
// The table lives in one synchronous RAM; a row of per-entry written bits
// makes every entry read as zero after reset, so the table is usable in the
// first cycle after rst drops, with no clearing pass.
// Acquire walks every entry through the RAM read port, one per cycle,
// looking for the lowest matching tag and the oldest free entry at once,
// then writes back the chosen entry, unless the hit is refused or no entry
// is free. Release, pin and unpin take a single read-modify-write of the
// addressed entry. An entry index beyond the table is refused without a
// RAM read.
// A result sits in an output register; the engine takes the next request
// while that result waits. If the receiver keeps stalling, a second
// finished result holds in the engine and req.ready stays low until the
// output register frees up.
module lru_block_buffer_cache_core #(
  parameter int ENTRIES = lbc_pkg::ENTRIES_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  lbc_req_if.sink  req,
  lbc_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic             eng_valid;
  logic             eng_ready;
  lbc_pkg::rsp_t    eng_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  lbc_pkg::entry_t  mem_wdata;
  lbc_pkg::entry_t  mem_rdata;

  logic             out_valid;
  lbc_pkg::rsp_t    out_data;

  lbc_ram #(
    .WIDTH ($bits(lbc_pkg::entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lbc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (eng_valid),
    .rsp_ready (eng_ready),
    .rsp_data  (eng_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  assign eng_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_valid && eng_ready) begin
      out_valid <= 1'b1;
      out_data  <= eng_data;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.result_entry     = out_data.result_entry;
  assign rsp.was_hit          = out_data.was_hit;
  assign rsp.disk_read_needed = out_data.disk_read_needed;
  assign rsp.status           = out_data.status;

endmodule

FILE: test/lbc_checker.sv
`timescale 1ns / 100ps

module lbc_checker (
  input  logic clk,
  input  logic rst,
  lbc_req_if   req,
  lbc_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  import lbc_pkg::*;

  localparam int ENTRIES = ENTRIES_DEFAULT;

  entry_t cache_model [ENTRIES];
  rsp_t   expected_rsp [$];
  rsp_t   oldest;
  rsp_t   observed;

  // Apply one request to the model table and return the result it must yield.
  function automatic rsp_t lookup_or_adjust(input logic [MODE_W-1:0]   m,
                                            input logic [DEVICE_W-1:0] dev,
                                            input logic [BLOCK_W-1:0]  blk,
                                            input logic [INDEX_W-1:0]  idx,
                                            input logic [TIME_W-1:0]   now);
    rsp_t r;
    bit   hit;
    bit   have_victim;
    int   pick;
    r = '0;
    hit = 1'b0;
    have_victim = 1'b0;
    pick = 0;
    if (m == MODE_ACQUIRE) begin
      // Lowest matching tag wins, valid or not.
      for (int i = 0; i < ENTRIES; i++) begin
        if (!hit && cache_model[i].tag_device == dev && cache_model[i].tag_block == blk) begin
          hit = 1'b1;
          pick = i;
        end
      end
      if (hit) begin
        r.result_entry = INDEX_W'(pick);
        r.was_hit = 1'b1;
        if (cache_model[pick].reference_count == COUNT_MAX) begin
          r.status = STATUS_REFUSED;
        end else begin
          cache_model[pick].reference_count = cache_model[pick].reference_count + 1'b1;
          r.disk_read_needed = !cache_model[pick].contents_valid;
          cache_model[pick].contents_valid = 1'b1;
          r.status = STATUS_OK;
        end
      end else begin
        // Strictly older wins, so ties stay with the lowest index.
        for (int i = 0; i < ENTRIES; i++) begin
          if (cache_model[i].reference_count == '0 &&
              (!have_victim || cache_model[i].last_use_time < cache_model[pick].last_use_time)) begin
            have_victim = 1'b1;
            pick = i;
          end
        end
        if (!have_victim) begin
          r.status = STATUS_NOFREE;
        end else begin
          cache_model[pick].tag_device = dev;
          cache_model[pick].tag_block = blk;
          cache_model[pick].reference_count = COUNT_W'(1);
          cache_model[pick].contents_valid = 1'b1;
          r.result_entry = INDEX_W'(pick);
          r.disk_read_needed = 1'b1;
          r.status = STATUS_OK;
        end
      end
    end else begin
      r.result_entry = idx;
      if (int'(idx) >= ENTRIES) begin
        r.status = STATUS_REFUSED;
      end else if (m == MODE_PIN) begin
        if (cache_model[idx].reference_count == COUNT_MAX) begin
          r.status = STATUS_REFUSED;
        end else begin
          cache_model[idx].reference_count = cache_model[idx].reference_count + 1'b1;
          r.status = STATUS_OK;
        end
      end else if (cache_model[idx].reference_count == '0) begin
        r.status = STATUS_REFUSED;
      end else begin
        cache_model[idx].reference_count = cache_model[idx].reference_count - 1'b1;
        // Only release stamps the time; unpin leaves it.
        if (m == MODE_RELEASE && cache_model[idx].reference_count == '0)
          cache_model[idx].last_use_time = now;
        r.status = STATUS_OK;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) cache_model[i] = '0;
      expected_rsp.delete();
    end else begin
      // Check the result before booking a request taken at the same edge.
      if (rsp.valid && rsp.ready) begin
        observed.result_entry = rsp.result_entry;
        observed.was_hit = rsp.was_hit;
        observed.disk_read_needed = rsp.disk_read_needed;
        observed.status = rsp.status;
        if (expected_rsp.size() == 0) begin
          $error("result with none outstanding: entry %0d status %0d",
                 observed.result_entry, observed.status);
          fail_count++;
        end else begin
          oldest = expected_rsp.pop_front();
          check_field("result_entry", oldest.result_entry, observed.result_entry);
          check_field("was_hit", oldest.was_hit, observed.was_hit);
          check_field("disk_read_needed", oldest.disk_read_needed, observed.disk_read_needed);
          check_field("status", oldest.status, observed.status);
        end
      end
      if (req.valid && req.ready)
        expected_rsp.push_back(lookup_or_adjust(req.mode, req.device, req.block_number,
                                                req.entry_index, req.current_time));
    end
    pending = expected_rsp.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import lbc_pkg::*;

  localparam int TOTAL_REQUESTS = 1650;
  localparam int HOLD_CYCLES    = 300;
  localparam int FILL_REQUESTS  = 34;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbc_req_if req_ch ();
  lbc_rsp_if rsp_ch ();

  int fail_count;
  int pending;

  lru_block_buffer_cache_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lbc_checker CHK (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int               sent = 0;
  bit               no_idle = 1'b0;
  int               hold_asked = 0;
  int               hold_given = 0;
  int               hold_left = 0;
  logic [TIME_W-1:0]  tick = '0;
  logic [BLOCK_W-1:0] fresh_blk = 32'h8000_0000;
  logic [INDEX_W-1:0] held_entries [$];

  // Remember entries granted to us so releases mostly hit referenced entries.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == STATUS_OK &&
        (rsp_ch.was_hit || rsp_ch.disk_read_needed))
      held_entries.push_back(rsp_ch.result_entry);
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_asked != hold_given) begin
        hold_given++;
        hold_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  function automatic logic [TIME_W-1:0] next_time();
    tick = tick + TIME_W'($urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) return $urandom;
    return tick;
  endfunction

  task automatic send_req(input logic [MODE_W-1:0]   m,
                          input logic [DEVICE_W-1:0] dev,
                          input logic [BLOCK_W-1:0]  blk,
                          input logic [INDEX_W-1:0]  idx,
                          input logic [TIME_W-1:0]   now);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= m;
    req_ch.device       <= dev;
    req_ch.block_number <= blk;
    req_ch.entry_index  <= idx;
    req_ch.current_time <= now;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic release_all_held();
    logic [INDEX_W-1:0] idx;
    wait_drained();
    while (held_entries.size() > 0) begin
      idx = held_entries.pop_front();
      send_req(MODE_RELEASE, DEVICE_W'($urandom), $urandom, idx, next_time());
    end
  endtask

  task automatic random_request();
    int                 pick;
    int                 pos;
    logic [DEVICE_W-1:0] dev;
    logic [BLOCK_W-1:0]  blk;
    logic [INDEX_W-1:0]  idx;
    pick = $urandom_range(0, 99);
    idx = INDEX_W'($urandom);
    if (pick < 42) begin
      // Mostly a small working set so hits are common.
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 3))
          0: dev = 8'h00;
          1: dev = 8'h01;
          2: dev = 8'hA5;
          default: dev = 8'hFF;
        endcase
        blk = ($urandom_range(0, 11) == 0) ? 32'hFFFF_FFFF : BLOCK_W'($urandom_range(0, 11));
      end else begin
        dev = DEVICE_W'($urandom);
        blk = $urandom;
      end
      send_req(MODE_ACQUIRE, dev, blk, idx, $urandom);
    end else if (pick < 78) begin
      if (held_entries.size() > 0 && $urandom_range(0, 99) < 85) begin
        pos = $urandom_range(0, held_entries.size() - 1);
        idx = held_entries[pos];
        held_entries.delete(pos);
      end
      send_req(MODE_RELEASE, DEVICE_W'($urandom), $urandom, idx, next_time());
    end else if (pick < 89) begin
      send_req(MODE_PIN, DEVICE_W'($urandom), $urandom, idx, $urandom);
    end else begin
      if (held_entries.size() > 0 && $urandom_range(0, 1) == 0) begin
        pos = $urandom_range(0, held_entries.size() - 1);
        idx = held_entries[pos];
        held_entries.delete(pos);
      end
      send_req(MODE_UNPIN, DEVICE_W'($urandom), $urandom, idx, next_time());
    end
  endtask

  initial begin
    int fills;
    fills = 0;
    req_ch.valid        <= 1'b0;
    req_ch.mode         <= MODE_ACQUIRE;
    req_ch.device       <= '0;
    req_ch.block_number <= '0;
    req_ch.entry_index  <= '0;
    req_ch.current_time <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset tags hit entry 0 invalid, then valid.
    send_req(MODE_ACQUIRE, 8'h00, 32'h0000_0000, 5'd31, 32'hFFFF_FFFF);
    send_req(MODE_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_0000);
    // Miss with all free times equal: lowest free index.
    send_req(MODE_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0000_0000);
    send_req(MODE_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF);
    send_req(MODE_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'hFFFF_FFFF);
    send_req(MODE_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_0001);
    send_req(MODE_UNPIN, 8'h00, 32'h0000_0000, 5'd2, 32'h0000_0000);
    send_req(MODE_PIN, 8'h00, 32'h0000_0000, 5'd2, 32'h0000_0000);
    // Unpin to zero leaves the time alone.
    send_req(MODE_UNPIN, 8'h00, 32'h0000_0000, 5'd2, 32'h5555_5555);
    send_req(MODE_RELEASE, 8'h00, 32'h0000_0000, 5'd1, 32'h0000_0000);
    send_req(MODE_ACQUIRE, 8'h01, 32'h0000_0001, 5'd0, 32'h0000_0000);
    send_req(MODE_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0000_0000);
    send_req(MODE_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'h0000_0000);
    send_req(MODE_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hAAAA_AAAA);
    send_req(MODE_PIN, 8'h00, 32'h0000_0000, 5'd31, 32'h0000_0000);
    send_req(MODE_RELEASE, 8'h00, 32'h0000_0000, 5'd31, 32'h0000_0002);
    send_req(MODE_RELEASE, 8'h00, 32'h0000_0000, 5'd1, 32'h0000_0000);
    send_req(MODE_RELEASE, 8'h00, 32'h0000_0000, 5'd2, 32'h0000_0000);
    send_req(MODE_ACQUIRE, 8'h5A, 32'h1234_5678, 5'd0, 32'h0000_0000);
    send_req(MODE_ACQUIRE, 8'h5A, 32'h1234_5678, 5'd0, 32'h0000_0000);
    wait_drained();
    held_entries.delete();

    // Pin one entry past its ceiling.
    repeat (256) send_req(MODE_PIN, DEVICE_W'($urandom), $urandom, 5'd30, $urandom);
    // Same tag until the hit is refused at the ceiling, then hand it all back.
    repeat (256) send_req(MODE_ACQUIRE, 8'hC3, 32'h0BAD_F00D, INDEX_W'($urandom), $urandom);
    release_all_held();

    while (sent < TOTAL_REQUESTS) begin
      if (hold_asked == 0 && sent >= 700) begin
        // Keep offering while the result side is held off.
        hold_asked = 1;
      end
      no_idle = (sent >= 1350 && sent < 1500);
      if (fills < 3 && sent >= 900 + fills * 150) begin
        // Fresh tags until no entry is left unreferenced.
        wait_drained();
        repeat (FILL_REQUESTS) begin
          send_req(MODE_ACQUIRE, 8'h7E, fresh_blk, INDEX_W'($urandom), $urandom);
          fresh_blk = fresh_blk + 1'b1;
        end
        release_all_held();
        fills++;
      end else begin
        random_request();
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
